[src/pwm_channel_generator_macros.svh]
// Assertion macros shared by the PWM channel generator RTL.
// Depends on nothing; users must provide clk and arst_n in scope.
`ifndef PWM_CHANNEL_GENERATOR_MACROS_SVH
`define PWM_CHANNEL_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/pcg_pkg.sv]
// Package for the PWM channel generator: register indexes, control and result types.
// No dependencies.
package pcg_pkg;

	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned SHIFT_FLD_W = 4;
	localparam int unsigned TDATA_W     = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE      = 3'd0,
		REG_ACTIVE_HIGH = 3'd1,
		REG_CLOCK_SHIFT = 3'd2,
		REG_PRESCALE    = 3'd3,
		REG_PER_MAX     = 3'd4,
		REG_ACTIVE_CNT  = 3'd5
	} reg_idx_t;

	// Fixed-width channel controls
	typedef struct packed {
		logic                   enable;
		logic                   active_high;
		logic [SHIFT_FLD_W-1:0] clock_shift;
	} ctrl_t;

	// One result beat
	typedef struct packed {
		logic period_start;
		logic drive_enable;
		logic level;
	} res_t;

endpackage

[src/pcg_cfg.sv]
// Configuration register file of the PWM channel generator.
// Depends on pcg_pkg.
module pcg_cfg #(
	parameter int unsigned PERIOD_BITS   = 16,
	parameter int unsigned PRESCALE_BITS = 8,
	parameter int unsigned CFG_W         = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pcg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	output pcg_pkg::ctrl_t                ctrl,
	output logic [PRESCALE_BITS-1:0]      prescale_minus_one,
	output logic [PERIOD_BITS-1:0]        period_minus_one,
	output logic [PERIOD_BITS-1:0]        active_count
);

	pcg_pkg::ctrl_t             ctrl_q;
	logic [PRESCALE_BITS-1:0]   prescale_q;
	logic [PERIOD_BITS-1:0]     period_q;
	logic [PERIOD_BITS-1:0]     active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.enable      <= 1'b0;
			ctrl_q.active_high <= 1'b1;
			ctrl_q.clock_shift <= '0;
			prescale_q         <= '0;
			period_q           <= '0;
			active_q           <= '0;
		end else if (cfg_we) begin
			case (pcg_pkg::reg_idx_t'(cfg_index))
				pcg_pkg::REG_ENABLE:      ctrl_q.enable      <= cfg_data[0];
				pcg_pkg::REG_ACTIVE_HIGH: ctrl_q.active_high <= cfg_data[0];
				pcg_pkg::REG_CLOCK_SHIFT: ctrl_q.clock_shift <= cfg_data[pcg_pkg::SHIFT_FLD_W-1:0];
				pcg_pkg::REG_PRESCALE:    prescale_q         <= cfg_data[PRESCALE_BITS-1:0];
				pcg_pkg::REG_PER_MAX:     period_q           <= cfg_data[PERIOD_BITS-1:0];
				pcg_pkg::REG_ACTIVE_CNT:  active_q           <= cfg_data[PERIOD_BITS-1:0];
				default: ; // unmapped index, ignored
			endcase
		end
	end

	assign ctrl               = ctrl_q;
	assign prescale_minus_one = prescale_q;
	assign period_minus_one   = period_q;
	assign active_count       = active_q;

endmodule

[src/pcg_core.sv]
// Divider chain, period counter and output level logic of the PWM channel.
// Depends on pcg_pkg.
module pcg_core #(
	parameter int unsigned PERIOD_BITS   = 16,
	parameter int unsigned PRESCALE_BITS = 8,
	parameter int unsigned MAX_SHIFT     = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic                     advance,
	input  pcg_pkg::ctrl_t           ctrl,
	input  logic [PRESCALE_BITS-1:0] prescale_minus_one,
	input  logic [PERIOD_BITS-1:0]   period_minus_one,
	input  logic [PERIOD_BITS-1:0]   active_count,
	output pcg_pkg::res_t            res
);

	localparam int unsigned SHIFT_W = (MAX_SHIFT > 0) ? MAX_SHIFT : 1;

	logic [SHIFT_W-1:0]              shift_cnt_q, shift_cnt_nxt, shift_lim;
	logic [PRESCALE_BITS-1:0]        pre_cnt_q, pre_cnt_nxt;
	logic [PERIOD_BITS-1:0]          pos_q, pos_nxt;
	logic [pcg_pkg::SHIFT_FLD_W-1:0] eff_shift;
	logic                            shift_wrap, pre_wrap, per_wrap, act;

	// clamp shift, then limit = 2^shift - 1 as a low-bit mask
	assign eff_shift = (ctrl.clock_shift > pcg_pkg::SHIFT_FLD_W'(MAX_SHIFT)) ?
		pcg_pkg::SHIFT_FLD_W'(MAX_SHIFT) : ctrl.clock_shift;
	assign shift_lim = (MAX_SHIFT > 0) ? ~({SHIFT_W{1'b1}} << eff_shift) : '0;

	assign shift_wrap = advance && (shift_cnt_q >= shift_lim);
	assign pre_wrap   = shift_wrap && (pre_cnt_q >= prescale_minus_one);
	assign per_wrap   = pre_wrap && (pos_q >= period_minus_one);

	always_comb begin
		shift_cnt_nxt = shift_cnt_q;
		pre_cnt_nxt   = pre_cnt_q;
		pos_nxt       = pos_q;
		if (!ctrl.enable) begin
			shift_cnt_nxt = '0;
			pre_cnt_nxt   = '0;
			pos_nxt       = '0;
		end else if (advance) begin
			shift_cnt_nxt = shift_wrap ? '0 : shift_cnt_q + SHIFT_W'(1);
			if (shift_wrap) begin
				pre_cnt_nxt = pre_wrap ? '0 : pre_cnt_q + PRESCALE_BITS'(1);
			end
			if (pre_wrap) begin
				pos_nxt = per_wrap ? '0 : pos_q + PERIOD_BITS'(1);
			end
		end
	end

	// active phase first; saturates once active_count reaches the period length
	assign act = (active_count > period_minus_one) || (pos_nxt < active_count);

	assign res.level        = ctrl.enable & (ctrl.active_high ? act : ~act);
	assign res.drive_enable = ctrl.enable;
	assign res.period_start = ctrl.enable & per_wrap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_cnt_q <= '0;
			pre_cnt_q   <= '0;
			pos_q       <= '0;
		end else if (step) begin
			shift_cnt_q <= shift_cnt_nxt;
			pre_cnt_q   <= pre_cnt_nxt;
			pos_q       <= pos_nxt;
		end
	end

endmodule

[src/pwm_channel_generator.sv]
// PWM channel generator, top level: stream ports, input and result registers.
// Depends on pcg_pkg, pcg_cfg, pcg_core and pwm_channel_generator_macros.svh.
//
// One PWM channel. Each input beat is one source-clock slot (advance = 1 means
// a tick passes). Ticks are divided by 2^clock_shift (clamped at MAX_SHIFT),
// then by prescale_minus_one+1; each divided clock steps a period counter of
// period_minus_one+1 counts. The output is active for the first active_count
// counts of the period, always active once active_count reaches the period length.
// Every input beat yields exactly one output beat carrying level, drive_enable
// and period_start, reflecting the counters after that tick. Disabled: counters
// held at zero, output beat all zeros (pin floats).
// Throughput is one beat per clock while the output is not stalled. A beat is
// held in the input register, then the counter update and level compare feed
// the result register, from which its result is offered on the output stream.
// The counter state advances as a beat moves into the result register, so a
// stall on the output side holds the counters. Configuration must be written by
// the user only while the block is idle; the block itself does not enforce this.
`include "pwm_channel_generator_macros.svh"

module pwm_channel_generator #(
	parameter int unsigned PERIOD_BITS   = 16,
	parameter int unsigned PRESCALE_BITS = 8,
	parameter int unsigned MAX_SHIFT     = 8,
	localparam int unsigned CFG_W = (PERIOD_BITS > PRESCALE_BITS) ? PERIOD_BITS : PRESCALE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [pcg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]              cfg_data,
	// input stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [pcg_pkg::TDATA_W-1:0]   s_axis_tdata,  // [0] advance, [7:1] zero
	// output stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [pcg_pkg::TDATA_W-1:0]   m_axis_tdata   // [0] level, [1] drive_enable,
	                                                     // [2] period_start, [7:3] zero
);

	pcg_pkg::ctrl_t           ctrl;
	logic [PRESCALE_BITS-1:0] prescale_minus_one;
	logic [PERIOD_BITS-1:0]   period_minus_one;
	logic [PERIOD_BITS-1:0]   active_count;

	logic          valid_s1, advance_s1;
	logic          out_valid_q;
	pcg_pkg::res_t out_res_q, res;
	logic          out_free, s1_fire, in_fire;

	pcg_cfg #(
		.PERIOD_BITS   (PERIOD_BITS),
		.PRESCALE_BITS (PRESCALE_BITS),
		.CFG_W         (CFG_W)
	) u_cfg (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.ctrl               (ctrl),
		.prescale_minus_one (prescale_minus_one),
		.period_minus_one   (period_minus_one),
		.active_count       (active_count)
	);

	// result register frees up when empty or being drained this cycle
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s1_fire       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			advance_s1 <= s_axis_tdata[0];
		end
	end

	// counters step when the beat moves on into the result register
	pcg_core #(
		.PERIOD_BITS   (PERIOD_BITS),
		.PRESCALE_BITS (PRESCALE_BITS),
		.MAX_SHIFT     (MAX_SHIFT)
	) u_core (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (s1_fire),
		.advance            (advance_s1),
		.ctrl               (ctrl),
		.prescale_minus_one (prescale_minus_one),
		.period_minus_one   (period_minus_one),
		.active_count       (active_count),
		.res                (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(pcg_pkg::TDATA_W-3){1'b0}}, out_res_q.period_start,
		out_res_q.drive_enable, out_res_q.level};

	// checks
	`PCG_ASSERT_NEXT(a_s1_to_out, s1_fire, m_axis_tvalid, "beat left s1 but no result")
	`PCG_ASSERT_SAME(a_ready_when_empty, !valid_s1, s_axis_tready, "stall with empty s1")
	`PCG_ASSERT_NEXT(a_drain_empties, m_axis_tvalid && m_axis_tready && !s1_fire,
		!m_axis_tvalid, "result register kept a drained beat")

endmodule
